FILE: rtl/jrdc_pkg.sv
// ---------------------------------------------------------------------------
// jrdc_pkg - shared types and constants
// Register map, mode codes and the per-axis settings bundle.
// ---------------------------------------------------------------------------
package jrdc_pkg;

    localparam int unsigned AXIS_W     = 8;
    localparam int unsigned QUOT_W     = 7;   // one quotient bit per divide stage
    localparam int unsigned DIV_STAGES = QUOT_W;
    localparam int unsigned LANE_DEPTH = DIV_STAGES + 1;   // entry stage + divide
    localparam int unsigned NUM_LANES  = 4;

    localparam logic [23:0] REMAP_RESET = 24'hFF8000;
    localparam logic [6:0]  FULL_SCALE  = 7'd127;
    localparam logic [7:0]  CENTRE_LO   = 8'h7F;
    localparam logic [8:0]  CENTRE_HI   = 9'h080;

    typedef enum logic [2:0] {
        REG_ENABLE     = 3'd0,
        REG_DEADZONES  = 3'd1,
        REG_THRESHOLDS = 3'd2,
        REG_REMAP_RX   = 3'd3,
        REG_REMAP_RY   = 3'd4,
        REG_REMAP_LX   = 3'd5,
        REG_REMAP_LY   = 3'd6,
        REG_NONE       = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_DIGITAL     = 2'd0,
        MODE_ANALOG      = 2'd1,
        MODE_ANALOG_FULL = 2'd2,
        MODE_UNDEFINED   = 2'd3
    } t_mode;

    typedef struct packed {
        logic       remap_en;
        logic [7:0] dz;
        logic [7:0] lo;
        logic [7:0] ctr;
        logic [7:0] hi;
    } t_axis_cfg;

endpackage

FILE: rtl/jrdc_axis_lane.sv
// ---------------------------------------------------------------------------
// jrdc_axis_lane - one axis: range remap, pipelined divide, deadzone
// Entry stage forms num/den and 127*num; seven restoring stages follow.
// ---------------------------------------------------------------------------
module jrdc_axis_lane (
    input  logic                 i_clk,
    input  logic                 i_adv,
    input  logic [7:0]           i_axis,
    input  jrdc_pkg::t_axis_cfg  i_cfg,
    output logic [7:0]           o_value,   // analog-mode result
    output logic [7:0]           o_raw      // untouched axis, same stage
);

    localparam int unsigned D = jrdc_pkg::LANE_DEPTH;
    localparam int unsigned Q = jrdc_pkg::QUOT_W;

    logic [7:0]   r_rem  [0:D-1];
    logic [Q-1:0] r_dlo  [0:D-1];
    logic [Q-1:0] r_q    [0:D-1];
    logic [7:0]   r_den  [0:D-1];
    logic         r_use  [0:D-1];
    logic [Q-1:0] r_cv   [0:D-1];
    logic         r_base [0:D-1];
    logic [7:0]   r_raw  [0:D-1];

    // entry: pick the segment and settle the special cases
    logic              below;
    logic signed [9:0] num, den, nn, dd;
    logic              n_use;
    logic [Q-1:0]      n_cv;
    logic [14:0]       prod;

    always_comb begin
        below = i_axis < i_cfg.ctr;
        num   = below ? ($signed({2'b00, i_axis})    - $signed({2'b00, i_cfg.lo}))
                      : ($signed({2'b00, i_axis})    - $signed({2'b00, i_cfg.ctr}));
        den   = below ? ($signed({2'b00, i_cfg.ctr}) - $signed({2'b00, i_cfg.lo}))
                      : ($signed({2'b00, i_cfg.hi})  - $signed({2'b00, i_cfg.ctr}));
        nn    = (den < 0) ? -num : num;
        dd    = (den < 0) ? -den : den;
        n_use = 1'b0;
        n_cv  = '0;
        if (den == 0) begin
            n_cv = (num < 0) ? '0 : jrdc_pkg::FULL_SCALE;
        end else if (nn <= 0) begin
            n_cv = '0;
        end else if (nn >= dd) begin
            n_cv = jrdc_pkg::FULL_SCALE;
        end else begin
            n_use = 1'b1;
        end
        prod = 15'(nn[7:0] * 8'd127);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0]  <= prod[14:Q];
            r_dlo[0]  <= prod[Q-1:0];
            r_q[0]    <= '0;
            r_den[0]  <= dd[7:0];
            r_use[0]  <= n_use;
            r_cv[0]   <= n_cv;
            r_base[0] <= ~below;
            r_raw[0]  <= i_axis;
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar k = 1; k < D; k++) begin : g_div
        localparam int unsigned BI = Q - k;
        logic [8:0]   t;
        logic         ge;
        logic [Q-1:0] n_q;
        always_comb begin
            t       = {r_rem[k-1], r_dlo[k-1][BI]};
            ge      = t >= {1'b0, r_den[k-1]};
            n_q     = r_q[k-1];
            n_q[BI] = ge;
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]     <= ge ? 8'(t - {1'b0, r_den[k-1]}) : t[7:0];
                r_dlo[k]     <= r_dlo[k-1];
                r_q[k]       <= n_q;
                r_den[k]     <= r_den[k-1];
                r_use[k]     <= r_use[k-1];
                r_cv[k]      <= r_cv[k-1];
                r_base[k]    <= r_base[k-1];
                r_raw[k]     <= r_raw[k-1];
            end
        end
    end

    // exit: remap select then deadzone
    logic [7:0] ax;
    logic [8:0] ax_dz;
    always_comb begin
        ax    = i_cfg.remap_en ? {r_base[D-1], (r_use[D-1] ? r_q[D-1] : r_cv[D-1])}
                               : r_raw[D-1];
        ax_dz = {1'b0, ax} + {1'b0, i_cfg.dz};
        if (i_cfg.dz != '0 && ax_dz > {1'b0, jrdc_pkg::CENTRE_LO}
                && {1'b0, ax} < (jrdc_pkg::CENTRE_HI + {1'b0, i_cfg.dz})) begin
            o_value = jrdc_pkg::CENTRE_LO;
        end else begin
            o_value = ax;
        end
        o_raw = r_raw[D-1];
    end

endmodule

FILE: rtl/joystick_range_deadzone_conditioner_unit.sv
// ---------------------------------------------------------------------------
// joystick_range_deadzone_conditioner_unit - stick calibration and deadzone
// Four axis lanes side by side, button merge and an output register.
// ---------------------------------------------------------------------------
// Takes one sample per cycle while not stalled. Each accepted sample passes
// through an entry stage that forms the remap numerator and 127*numerator,
// seven restoring divide stages (one quotient bit each, one divider per
// axis lane), then the output register. The whole pipeline
// stalls together when the output register is full and not taken, so a new
// sample is accepted whenever the output is empty or being taken in the same
// cycle. Configuration over the APB port: write only while no transaction is
// in flight. Registers sit at byte addresses 0x00 enable, 0x04 deadzones,
// 0x08 digital thresholds, 0x0C..0x18 remap right X, right Y, left X, left Y.
module joystick_range_deadzone_conditioner_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // right_x, right_y, left_x, left_y, button_levels
    input  logic [1:0]  i_s_tuser,   // mode
    // sample out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // right_x, right_y, left_x, left_y, button_result
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned D = jrdc_pkg::LANE_DEPTH;

    // --- configuration registers ---
    logic [3:0]  r_enable;
    logic [15:0] r_dz;
    logic [15:0] r_thr;
    logic [23:0] r_remap [0:jrdc_pkg::NUM_LANES-1];

    jrdc_pkg::t_reg_idx widx;
    logic               wr;

    assign pready = 1'b1;
    assign widx   = jrdc_pkg::t_reg_idx'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            r_dz     <= '0;
            r_thr    <= '0;
            for (int i = 0; i < jrdc_pkg::NUM_LANES; i++) begin
                r_remap[i] <= jrdc_pkg::REMAP_RESET;
            end
        end else if (wr) begin
            unique case (widx)
                jrdc_pkg::REG_ENABLE:     r_enable   <= pwdata[3:0];
                jrdc_pkg::REG_DEADZONES:  r_dz       <= pwdata[15:0];
                jrdc_pkg::REG_THRESHOLDS: r_thr      <= pwdata[15:0];
                jrdc_pkg::REG_REMAP_RX:   r_remap[0] <= pwdata[23:0];
                jrdc_pkg::REG_REMAP_RY:   r_remap[1] <= pwdata[23:0];
                jrdc_pkg::REG_REMAP_LX:   r_remap[2] <= pwdata[23:0];
                jrdc_pkg::REG_REMAP_LY:   r_remap[3] <= pwdata[23:0];
                default: ;   // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            jrdc_pkg::REG_ENABLE:     prdata = {28'd0, r_enable};
            jrdc_pkg::REG_DEADZONES:  prdata = {16'd0, r_dz};
            jrdc_pkg::REG_THRESHOLDS: prdata = {16'd0, r_thr};
            jrdc_pkg::REG_REMAP_RX:   prdata = {8'd0, r_remap[0]};
            jrdc_pkg::REG_REMAP_RY:   prdata = {8'd0, r_remap[1]};
            jrdc_pkg::REG_REMAP_LX:   prdata = {8'd0, r_remap[2]};
            jrdc_pkg::REG_REMAP_LY:   prdata = {8'd0, r_remap[3]};
            default:                  prdata = '0;
        endcase
    end

    // --- pipeline control: one global advance ---
    logic         adv;
    logic         r_vld [0:D-1];
    logic         r_out_vld;
    logic         r_ana [0:D-1];    // sample takes the analog path
    logic [7:0]   r_btn [0:D-1];    // buttons already merged at entry

    assign adv        = !r_out_vld || i_m_tready;
    assign o_s_tready = adv;
    assign o_m_tvalid = r_out_vld;

    // digital emulation, done at entry (adds and compares only, no divide)
    function automatic logic [3:0] emulate(input logic [7:0] x, input logic [7:0] y,
                                           input logic [7:0] t);
        logic [8:0] xt, yt, hi;
        xt = {1'b0, x} + {1'b0, t};
        yt = {1'b0, y} + {1'b0, t};
        hi = jrdc_pkg::CENTRE_HI + {1'b0, t};
        emulate = { ({1'b0, y} > hi), (yt < {1'b0, jrdc_pkg::CENTRE_LO}),
                    ({1'b0, x} > hi), (xt < {1'b0, jrdc_pkg::CENTRE_LO}) };
    endfunction

    jrdc_pkg::t_mode in_mode;
    logic            in_ana;
    logic [7:0]      in_btn;

    always_comb begin
        in_mode = jrdc_pkg::t_mode'(i_s_tuser);
        in_ana  = r_enable[0] && (in_mode == jrdc_pkg::MODE_ANALOG
                                  || in_mode == jrdc_pkg::MODE_ANALOG_FULL);
        in_btn  = i_s_tdata[39:32];
        if (r_enable[0] && in_mode == jrdc_pkg::MODE_DIGITAL) begin
            if (r_enable[2]) begin
                in_btn[3:0] = in_btn[3:0]
                            | emulate(i_s_tdata[23:16], i_s_tdata[31:24], r_thr[7:0]);
            end
            if (r_enable[3]) begin
                in_btn[7:4] = in_btn[7:4]
                            | emulate(i_s_tdata[7:0], i_s_tdata[15:8], r_thr[15:8]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < D; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_s_tvalid;
            for (int i = 1; i < D; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_out_vld <= r_vld[D-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ana[0] <= in_ana;
            r_btn[0] <= in_btn;
            for (int i = 1; i < D; i++) begin
                r_ana[i] <= r_ana[i-1];
                r_btn[i] <= r_btn[i-1];
            end
        end
    end

    // --- axis lanes: 0 right X, 1 right Y, 2 left X, 3 left Y ---
    logic [7:0] lane_val [0:jrdc_pkg::NUM_LANES-1];
    logic [7:0] lane_raw [0:jrdc_pkg::NUM_LANES-1];

    for (genvar g = 0; g < jrdc_pkg::NUM_LANES; g++) begin : g_lane
        jrdc_pkg::t_axis_cfg cfg;
        assign cfg = '{remap_en: r_enable[1],
                       dz:       (g < 2) ? r_dz[15:8] : r_dz[7:0],
                       lo:       r_remap[g][7:0],
                       ctr:      r_remap[g][15:8],
                       hi:       r_remap[g][23:16]};
        jrdc_axis_lane u_lane (
            .i_clk   (i_clk),
            .i_adv   (adv),
            .i_axis  (i_s_tdata[8*g +: 8]),
            .i_cfg   (cfg),
            .o_value (lane_val[g]),
            .o_raw   (lane_raw[g])
        );
    end

    // --- merge and output register ---
    logic [39:0] r_out;
    logic [39:0] n_out;

    always_comb begin
        for (int i = 0; i < jrdc_pkg::NUM_LANES; i++) begin
            n_out[8*i +: 8] = r_ana[D-1] ? lane_val[i] : lane_raw[i];
        end
        n_out[39:32] = r_btn[D-1];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_tdata = r_out;

`ifndef SYNTHESIS
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_vld[D-1]) |=> r_out_vld)
        else $error("finished sample not moved to output");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> (r_out_vld && $stable(r_out)))
        else $error("stalled result lost or changed");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv) |=> $stable(r_vld[D-1]))
        else $error("pipeline moved during stall");
`endif

endmodule
